/* sv/multilevel_feedback_queue_scheduler_defines.svh */
// Assertion macros for the MLFQ scheduler checker.
// Included by the checker only; no dependencies.
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MLFQ_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MLFQ_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

/* sv/mlfq_pkg.sv */
// Shared types and constants for the MLFQ scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mlfq_pkg;
    localparam int MAX_PROCS  = 64;
    localparam int NUM_LEVELS = 8;
    localparam int PW = $clog2(MAX_PROCS);
    localparam int CW = PW + 1;
    localparam int LW = $clog2(NUM_LEVELS);
    localparam int TW = 24;

    typedef struct packed {
        logic [15:0] arrival_time;
        logic [15:0] run_length;
        logic        last_process;
    } t_in;

    typedef struct packed {
        logic [5:0]    process_index;
        logic [TW-1:0] start_time;
        logic [TW-1:0] finish_time;
        logic [TW-1:0] turnaround;
        logic          last_result;
    } t_out;

    typedef struct packed {
        logic          clear;
        logic          push;
        logic [LW-1:0] push_lvl;
        logic [PW-1:0] push_proc;
        logic          pop;
        logic [LW-1:0] pop_lvl;
    } t_lvl_req;

    typedef struct packed {
        logic          busy;
        logic [LW-1:0] low_lvl;
    } t_lvl_stat;
endpackage
`default_nettype wire

/* sv/mlfq_levels.sv */
// Level queues: one circular queue per level in a shared memory,
// heads and counts in flops. Depends on mlfq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mlfq_levels
    import mlfq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_lvl_req  i_req,
    output t_lvl_stat      o_stat,
    output logic [PW-1:0]  o_pop_proc
);
    logic [PW-1:0] r_queue [NUM_LEVELS*MAX_PROCS];
    logic [PW-1:0] r_head  [NUM_LEVELS];
    logic [CW-1:0] r_count [NUM_LEVELS];
    logic [PW-1:0] push_slot;

    assign push_slot = r_head[i_req.push_lvl] + r_count[i_req.push_lvl][PW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_queue[{i_req.push_lvl, push_slot}] <= i_req.push_proc;
        end
        o_pop_proc <= r_queue[{i_req.pop_lvl, r_head[i_req.pop_lvl]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clear) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            if (i_req.push) begin
                r_count[i_req.push_lvl] <= r_count[i_req.push_lvl] + CW'(1);
            end
            if (i_req.pop) begin
                r_head[i_req.pop_lvl]  <= r_head[i_req.pop_lvl] + PW'(1);
                r_count[i_req.pop_lvl] <= r_count[i_req.pop_lvl] - CW'(1);
            end
        end
    end

    // lowest non-empty level
    always_comb begin
        o_stat = '0;
        for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
            if (r_count[k] != '0) begin
                o_stat.busy    = 1'b1;
                o_stat.low_lvl = LW'(k);
            end
        end
    end
endmodule
`default_nettype wire

/* sv/multilevel_feedback_queue_scheduler.sv */
// MLFQ scheduler top: records load at one item per cycle into the process memories.
// The last record starts the schedule: a pass that serves a process runs check, admit, pick,
// fetch, serve, one with all levels empty runs check, admit, pick; results hold on stall.
// Synchronous active-low reset clears control state and sets the slice to 1.
// Depends on mlfq_pkg and mlfq_levels.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_feedback_queue_scheduler
    import mlfq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_in         i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_out             o_data
);
    typedef enum logic [8:0] {
        S_LOAD  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_ADMIT = 9'b000000100,
        S_PICK  = 9'b000001000,
        S_FETCH = 9'b000010000,
        S_SERVE = 9'b000100000,
        S_ORD   = 9'b001000000,
        S_OCAP  = 9'b010000000,
        S_OWAIT = 9'b100000000
    } t_state;

    typedef struct packed {
        logic          started;
        logic [15:0]   served;
        logic [TW-1:0] start;
        logic [TW-1:0] finish;
    } t_run;

    t_state        r_state, n_state;
    logic [15:0]   r_slice;
    logic [CW-1:0] r_loaded, r_adm, r_oidx;
    logic [TW-1:0] r_tick, r_prev;
    logic [LW-1:0] r_lvl;
    logic [PW-1:0] r_proc;

    logic [31:0]   r_rec  [MAX_PROCS];
    t_run          r_run  [MAX_PROCS];
    logic [31:0]   r_rec_q;
    t_run          r_run_q;

    logic [PW-1:0] rd_addr;
    logic          rec_we, run_we;
    logic [PW-1:0] wr_addr;
    t_run          run_wd;

    t_lvl_req      lreq;
    t_lvl_stat     lstat;
    logic [PW-1:0] pop_proc;

    logic [15:0]   slice, arr, len, rem, tt;
    logic          admit, done;

    mlfq_levels u_levels (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (lreq),
        .o_stat    (lstat),
        .o_pop_proc(pop_proc)
    );

    assign slice = (r_slice == '0) ? 16'd1 : r_slice;
    assign arr   = r_rec_q[31:16];
    assign len   = r_rec_q[15:0];
    assign rem   = len - r_run_q.served;
    assign tt    = (rem < slice) ? rem : slice;
    assign done  = (r_run_q.served + tt) == len;
    assign admit = (r_adm < r_loaded) && (r_tick >= {8'd0, arr});
    assign o_ready = (r_state == S_LOAD);

    always_comb begin
        case (r_state)
            S_CHECK: rd_addr = r_adm[PW-1:0];
            S_FETCH: rd_addr = pop_proc;
            default: rd_addr = r_oidx[PW-1:0];
        endcase
    end

    // memory write side
    always_comb begin
        rec_we  = 1'b0;
        run_we  = 1'b0;
        wr_addr = r_proc;
        run_wd  = r_run_q;
        if (r_state == S_LOAD) begin
            wr_addr = r_loaded[PW-1:0];
            rec_we  = i_valid && (r_loaded != CW'(MAX_PROCS));
            run_we  = rec_we;
            run_wd  = '0;
        end else if (r_state == S_SERVE) begin
            run_we        = 1'b1;
            run_wd.served = r_run_q.served + tt;
            if (!r_run_q.started) begin
                run_wd.started = 1'b1;
                run_wd.start   = r_tick;
            end
            if (done) begin
                run_wd.finish = r_tick + TW'(tt);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rec[wr_addr] <= {i_data.arrival_time, i_data.run_length};
        end
        if (run_we) begin
            r_run[wr_addr] <= run_wd;
        end
        r_rec_q <= r_rec[rd_addr];
        r_run_q <= r_run[rd_addr];
    end

    always_comb begin
        lreq           = '0;
        lreq.pop_lvl   = lstat.low_lvl;
        lreq.push_proc = r_proc;
        case (r_state)
            S_ADMIT: begin
                lreq.push      = admit;
                lreq.push_proc = r_adm[PW-1:0];
            end
            S_PICK:  lreq.pop = lstat.busy;
            S_SERVE: begin
                lreq.push     = !done;
                lreq.push_lvl = (r_lvl == LW'(NUM_LEVELS - 1)) ? r_lvl : r_lvl + LW'(1);
            end
            S_OWAIT: lreq.clear = i_ready && o_data.last_result;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (i_valid && i_data.last_process) n_state = S_CHECK;
            S_CHECK: n_state = ((r_adm < r_loaded) || lstat.busy) ? S_ADMIT : S_ORD;
            S_ADMIT: n_state = S_PICK;
            S_PICK:  n_state = lstat.busy ? S_FETCH : S_CHECK;
            S_FETCH: n_state = S_SERVE;
            S_SERVE: n_state = S_CHECK;
            S_ORD:   n_state = S_OCAP;
            S_OCAP:  n_state = S_OWAIT;
            S_OWAIT: begin
                if (i_ready) n_state = o_data.last_result ? S_LOAD : S_ORD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_slice  <= 16'd1;
            r_loaded <= '0;
            r_adm    <= '0;
            r_oidx   <= '0;
            r_tick   <= '0;
            r_prev   <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_slice <= i_cfg_data;
            case (r_state)
                S_LOAD: begin
                    if (rec_we) r_loaded <= r_loaded + CW'(1);
                    r_oidx <= '0;
                end
                S_ADMIT: begin
                    if (admit) begin
                        // snap to the arrival when nothing is queued
                        if (!lstat.busy && ({8'd0, arr} >= r_prev)) r_tick <= {8'd0, arr};
                        r_adm <= r_adm + CW'(1);
                    end
                end
                S_PICK: begin
                    if (!lstat.busy) r_tick <= r_tick + TW'(slice);
                    r_lvl <= lstat.low_lvl;
                end
                S_FETCH: r_proc <= pop_proc;
                S_SERVE: begin
                    r_tick <= r_tick + TW'(tt);
                    if (done) r_prev <= r_tick + TW'(tt);
                end
                S_OCAP: o_valid <= 1'b1;
                S_OWAIT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_oidx  <= r_oidx + CW'(1);
                        if (o_data.last_result) begin
                            r_loaded <= '0;
                            r_adm    <= '0;
                            r_tick   <= '0;
                            r_prev   <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OCAP) begin
            o_data.process_index <= 6'(r_oidx[PW-1:0]);
            o_data.start_time    <= r_run_q.start;
            o_data.finish_time   <= r_run_q.finish;
            o_data.turnaround    <= r_run_q.finish - {8'd0, arr};
            o_data.last_result   <= (r_oidx + CW'(1)) == r_loaded;
        end
    end
endmodule
`default_nettype wire

/* sv/mlfq_checker.sv */
// Port-level checks for the MLFQ scheduler, bound to the top level.
// Depends on mlfq_pkg and multilevel_feedback_queue_scheduler_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "multilevel_feedback_queue_scheduler_defines.svh"
module mlfq_checker
    import mlfq_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_ready,
    input wire t_in  i_data,
    input wire logic o_valid,
    input wire logic i_ready,
    input wire t_out o_data
);
    `MLFQ_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_data), "result item dropped or changed while stalled")
    `MLFQ_ASSERT_NOW(a_no_load_while_report, o_valid, !o_ready, "input taken while results pending")
    `MLFQ_ASSERT_NEXT(a_last_in_starts, i_valid && o_ready && i_data.last_process, !o_ready && !o_valid, "schedule did not start on last record")
    `MLFQ_ASSERT_NEXT(a_last_out_ends, o_valid && i_ready && o_data.last_result, !o_valid && o_ready, "block not back to loading after final result")
endmodule

bind multilevel_feedback_queue_scheduler mlfq_checker u_mlfq_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_valid(i_valid),
    .o_ready(o_ready),
    .i_data (i_data),
    .o_valid(o_valid),
    .i_ready(i_ready),
    .o_data (o_data)
);
`default_nettype wire
